// ===== sv/lcpr_pkg.sv =====
// shared types and constants of the layered colormap pixel renderer
package lcpr_pkg;

    // one rgba pixel, red in the lowest bits
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // configuration register indexes
    localparam logic [2:0] CFG_VALUE_MIN     = 3'd0;
    localparam logic [2:0] CFG_VALUE_MAX     = 3'd1;
    localparam logic [2:0] CFG_COLORMAP_SIZE = 3'd2;
    localparam logic [2:0] CFG_OPACITY_BASE  = 3'd3;
    localparam logic [2:0] CFG_OPACITY_SAFE  = 3'd4;
    localparam logic [2:0] CFG_OPACITY_AVOID = 3'd5;
    localparam logic [2:0] CFG_NOFLY_MODE    = 3'd6;

    // how the base layer of a pixel is drawn
    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_STRIPE = 3'd1;
    localparam logic [2:0] KIND_BLACK  = 3'd2;
    localparam logic [2:0] KIND_FIRST  = 3'd3;
    localparam logic [2:0] KIND_LAST   = 3'd4;
    localparam logic [2:0] KIND_INTERP = 3'd5;

    // fixed point and field widths
    localparam int FRAC_BITS = 16;
    localparam int SIZE_W    = 9;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

    // no-fly stripes
    localparam int         STRIPE_PERIOD = 32;
    localparam logic [8:0] STRIPE_WIDTH  = 9'd4;
    localparam logic [7:0] STRIPE_RED    = 8'd255;
    localparam logic [7:0] STRIPE_GB     = 8'd40;

    // overlays are drawn where the sample is above one half
    localparam logic signed [31:0] OVERLAY_THRESH = 32'sd32768;
    localparam logic [23:0]        SAFE_RGB       = 24'h00C800;
    localparam logic [23:0]        AVOID_RGB      = 24'hF0F000;

endpackage

// ===== sv/lcpr_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, shared divisor
module lcpr_divider #(
    parameter int LANES = 1,
    parameter int NW    = 24,
    parameter int DW    = 16,
    parameter int QW    = 8,
    parameter int SW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   dividend,
    input  logic [DW-1:0]              divisor,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   quotient,
    output logic [SW-1:0]              out_side
);
    // the dividend must satisfy dividend < divisor * 2**QW

    logic [QW-1:0]    v_reg;
    logic [DW-1:0]    rem_reg  [QW][LANES];
    logic [QW-1:0]    low_reg  [QW][LANES];
    logic [DW-1:0]    dvs_reg  [QW];
    logic [SW-1:0]    side_reg [QW];

    logic [DW-1:0]    rem_in   [QW][LANES];
    logic [QW-1:0]    low_in   [QW][LANES];
    logic [DW-1:0]    dvs_in   [QW];
    logic [DW:0]      trial    [QW][LANES];
    logic [DW:0]      sub      [QW][LANES];
    logic [DW-1:0]    rem_next [QW][LANES];
    logic [QW-1:0]    low_next [QW][LANES];
    logic [NW+DW-1:0] wide     [LANES];

    // one compare and subtract per stage
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            wide[l] = {{DW{1'b0}}, dividend[l]} >> QW;
        end
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                dvs_in[k] = divisor;
            end
            else
            begin
                dvs_in[k] = dvs_reg[k-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                if (k == 0)
                begin
                    rem_in[k][l] = wide[l][DW-1:0];
                    low_in[k][l] = dividend[l][QW-1:0];
                end
                else
                begin
                    rem_in[k][l] = rem_reg[k-1][l];
                    low_in[k][l] = low_reg[k-1][l];
                end
                trial[k][l] = {rem_in[k][l], low_in[k][l][QW-1]};
                sub[k][l]   = trial[k][l] - {1'b0, dvs_in[k]};
                if (trial[k][l] >= {1'b0, dvs_in[k]})
                begin
                    rem_next[k][l] = sub[k][l][DW-1:0];
                    low_next[k][l] = {low_in[k][l][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = trial[k][l][DW-1:0];
                    low_next[k][l] = {low_in[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                dvs_reg[k] <= dvs_in[k];
                if (k == 0)
                begin
                    side_reg[k] <= in_side;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    low_reg[k][l] <= low_next[k][l];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quotient[l] = low_reg[QW-1][l];
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== sv/lcpr_over.sv =====
// over compositing of one constant colored overlay onto a pixel
module lcpr_over (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lcpr_pkg::pixel_t in_px,
    input  logic            in_on,
    input  logic            in_flag,
    input  logic [23:0]     front_rgb,
    input  logic [7:0]      opacity,
    output logic            out_valid,
    output lcpr_pkg::pixel_t out_px,
    output logic            out_flag
);
    import lcpr_pkg::*;

    typedef struct packed {
        pixel_t px;
        logic   on;
        logic   flag;
    } ovl_ctl_t;

    typedef struct packed {
        pixel_t     px;
        logic       on;
        logic       flag;
        logic [7:0] alpha;
    } ovl_side_t;

    logic           v1_reg, v2_reg, v3_reg, v4_reg, vout_reg;
    ovl_ctl_t       ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [15:0]    y1_reg, y2_reg;
    logic [8:0]     q0_reg;
    logic [15:0]    d_reg, o3_reg, o_reg;
    logic [2:0][23:0] num_reg;
    pixel_t         px_out_reg;
    logic           flag_out_reg;

    logic [15:0]    y_next;
    logic [16:0]    yp;
    logic [16:0]    q0_sum;
    logic [8:0]     q0_next;
    logic [16:0]    q255;
    logic signed [17:0] rdiff;
    logic [8:0]     q_fix;
    logic [15:0]    d_next, o_next;
    logic [2:0][23:0] num_next;
    logic [15:0]    dvs_next;
    logic [7:0]     cf [3];
    logic [7:0]     cb [3];
    logic [23:0]    fpart [3];
    logic [23:0]    bpart [3];
    ovl_side_t      side_in, side_out;
    logic           vq;
    logic [2:0][7:0] q;
    pixel_t         px_next;

    // back alpha times front transparency
    assign y_next = 16'({8'd0, in_px.alpha} * {8'd0, 8'(ALPHA_MAX - opacity)});

    // estimate of y / 255
    always_comb
    begin
        yp      = {1'b0, y1_reg} + 17'd1;
        q0_sum  = yp + (yp >> 8);
        q0_next = q0_sum[16:8];
    end

    // exact y / 255, then back alpha share d and total alpha o
    always_comb
    begin
        q255  = {q0_reg, 8'd0} - {8'd0, q0_reg};
        rdiff = $signed({2'b00, y2_reg}) - $signed({1'b0, q255});
        if (rdiff < 0)
        begin
            q_fix = q0_reg - 9'd1;
        end
        else if (rdiff >= 18'sd255)
        begin
            q_fix = q0_reg + 9'd1;
        end
        else
        begin
            q_fix = q0_reg;
        end
        d_next = 16'(y2_reg + {7'd0, q_fix});
        o_next = 16'({opacity, 8'd0} + d_next);
    end

    // channel numerators
    always_comb
    begin
        cf[0] = front_rgb[23:16];
        cf[1] = front_rgb[15:8];
        cf[2] = front_rgb[7:0];
        cb[0] = ctl3_reg.px.red;
        cb[1] = ctl3_reg.px.green;
        cb[2] = ctl3_reg.px.blue;
        for (int c = 0; c < 3; c++)
        begin
            fpart[c] = {16'({8'd0, cf[c]} * {8'd0, opacity}), 8'd0};
            bpart[c] = 24'({16'd0, cb[c]} * {8'd0, d_reg});
            if (ctl3_reg.on)
            begin
                num_next[c] = fpart[c] + bpart[c];
            end
            else
            begin
                num_next[c] = '0;
            end
        end
        dvs_next = ctl3_reg.on ? o3_reg : 16'd1;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= '{px: in_px, on: in_on, flag: in_flag};
            y1_reg   <= y_next;
            ctl2_reg <= ctl1_reg;
            y2_reg   <= y1_reg;
            q0_reg   <= q0_next;
            ctl3_reg <= ctl2_reg;
            d_reg    <= d_next;
            o3_reg   <= o_next;
            ctl4_reg <= ctl3_reg;
            num_reg  <= num_next;
            o_reg    <= dvs_next;
        end
    end

    assign side_in = '{px: ctl4_reg.px, on: ctl4_reg.on, flag: ctl4_reg.flag,
                       alpha: o_reg[15:8]};

    lcpr_divider #(
        .LANES (3),
        .NW    (24),
        .DW    (16),
        .QW    (8),
        .SW    ($bits(ovl_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  (num_reg),
        .divisor   (o_reg),
        .in_side   (side_in),
        .out_valid (vq),
        .quotient  (q),
        .out_side  (side_out)
    );

    // pick the composited pixel or pass the old one
    always_comb
    begin
        if (side_out.on)
        begin
            px_next.red   = q[0];
            px_next.green = q[1];
            px_next.blue  = q[2];
            px_next.alpha = side_out.alpha;
        end
        else
        begin
            px_next = side_out.px;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_out_reg   <= px_next;
            flag_out_reg <= side_out.flag;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            vout_reg <= vq;
        end
    end

    assign out_valid = vout_reg;
    assign out_px    = px_out_reg;
    assign out_flag  = flag_out_reg;

endmodule

// ===== sv/layered_colormap_pixel_renderer_unit.sv =====
// top level of the layered colormap pixel renderer
//
// Items arrive on the s_axis channel. tuser bit 0 picks the kind of item:
// 0 loads one colormap entry, 1 renders one pixel. A load gives no result,
// a render gives one rgba pixel on m_axis (red in the lowest byte).
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while no item is in flight.
// One item is taken every clock while no pixel waits at a stalled output. A
// pixel passes stage a, stage b, the interpolation divider, the table stage,
// the interpolation stage and the two overlay stages, each of which holds its
// own channel divider.
// Loads travel the same pipeline and write the colormap at the stage where
// renders read it, so load and render order is kept.
// Reset clears all valid bits and loads the register defaults; the colormap
// itself is not cleared and an entry must be loaded before it is used.
// When the receiver holds m_axis_tready low with a pixel waiting, the whole
// pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module layered_colormap_pixel_renderer_unit #(
    parameter int MAX_COLORS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, entry_rgb, pixel_row, pixel_col, base_value, safe_value,
    // avoid_value
    input  logic [143:0] s_axis_tdata,
    // mode, base_is_nan, safe_is_nan, avoid_is_nan
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // red, green, blue, alpha
    output logic [31:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import lcpr_pkg::*;

    localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int QW = AW + FRAC_BITS;
    localparam int PW = 32 + SIZE_W;
    localparam int NW = PW + FRAC_BITS;

    typedef struct packed {
        logic              mode;
        logic [7:0]        idx;
        logic [23:0]       rgb;
        logic [2:0]        kind;
        logic [SIZE_W-1:0] n;
        logic              safe_on;
        logic              avoid_on;
    } item_ctl_t;

    // input fields
    logic              in_mode, in_base_nan, in_safe_nan, in_avoid_nan;
    logic [7:0]        in_idx, in_row, in_col;
    logic [23:0]       in_rgb;
    logic [31:0]       in_base, in_safe, in_avoid;

    // configuration
    logic [31:0]       value_min_reg, value_max_reg;
    logic [SIZE_W-1:0] colormap_size_reg;
    logic [7:0]        opacity_base_reg, opacity_safe_reg, opacity_avoid_reg;
    logic              nofly_mode_reg;

    logic              adv;

    // classification
    logic [SIZE_W-1:0] n_cur;
    logic signed [32:0] lo_ext, hi_ext, v_ext, range_cur, diff_full;
    logic [8:0]        diag;
    logic              stripe_hit;
    item_ctl_t         ctl_cur;

    // stages before the divider
    logic              va_reg, vb_reg;
    item_ctl_t         ctl_a_reg, ctl_b_reg;
    logic [31:0]       diff_a_reg, range_a_reg, range_b_reg;
    logic [PW-1:0]     prod_b_reg;
    logic [NW-1:0]     num_b;
    logic [31:0]       dvs_b;

    // divider outputs and table stage
    logic              vq;
    logic [QW-1:0]     p_q;
    item_ctl_t         ctl_q;
    logic [SIZE_W-1:0] nm1, nm2;
    logic [AW-1:0]     i_raw, rd_a, rd_b;
    logic [15:0]       s_cur;
    logic              wr_en;
    logic [23:0]       cmap_mem [MAX_COLORS];

    logic              vc_reg;
    logic [2:0]        kind_c_reg;
    logic [15:0]       s_c_reg;
    logic              safe_c_reg, avoid_c_reg;
    logic [23:0]       c1_reg, c2_reg;

    // interpolation stage
    logic [16:0]       w_lo;
    logic [24:0]       acc [3];
    logic [7:0]        mix [3];
    pixel_t            px_base;
    logic              vd_reg, safe_d_reg, avoid_d_reg;
    pixel_t            px_d_reg;

    // overlays
    logic              v_o1, avoid_o1, v_o2;
    pixel_t            px_o1, px_o2;

    assign in_mode      = s_axis_tuser[0];
    assign in_base_nan  = s_axis_tuser[1];
    assign in_safe_nan  = s_axis_tuser[2];
    assign in_avoid_nan = s_axis_tuser[3];
    assign in_idx       = s_axis_tdata[7:0];
    assign in_rgb       = s_axis_tdata[31:8];
    assign in_row       = s_axis_tdata[39:32];
    assign in_col       = s_axis_tdata[47:40];
    assign in_base      = s_axis_tdata[79:48];
    assign in_safe      = s_axis_tdata[111:80];
    assign in_avoid     = s_axis_tdata[143:112];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_min_reg     <= 32'd0;
            value_max_reg     <= 32'd6553600;
            colormap_size_reg <= '0;
            opacity_base_reg  <= 8'd255;
            opacity_safe_reg  <= 8'd0;
            opacity_avoid_reg <= 8'd0;
            nofly_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VALUE_MIN:     value_min_reg     <= cfg_wdata;
                CFG_VALUE_MAX:     value_max_reg     <= cfg_wdata;
                CFG_COLORMAP_SIZE: colormap_size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_OPACITY_BASE:  opacity_base_reg  <= cfg_wdata[7:0];
                CFG_OPACITY_SAFE:  opacity_safe_reg  <= cfg_wdata[7:0];
                CFG_OPACITY_AVOID: opacity_avoid_reg <= cfg_wdata[7:0];
                CFG_NOFLY_MODE:    nofly_mode_reg    <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // global advance: hold the whole pipeline while a pixel waits at the output
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // sort the item into its base layer case
    always_comb
    begin
        if (int'(colormap_size_reg) > MAX_COLORS)
        begin
            n_cur = SIZE_W'(MAX_COLORS);
        end
        else
        begin
            n_cur = colormap_size_reg;
        end
        lo_ext     = $signed({value_min_reg[31], value_min_reg});
        hi_ext     = $signed({value_max_reg[31], value_max_reg});
        v_ext      = $signed({in_base[31], in_base});
        range_cur  = hi_ext - lo_ext;
        diff_full  = v_ext - lo_ext;
        diag       = {1'b0, in_row} + {1'b0, in_col};
        stripe_hit = nofly_mode_reg && ((diag % STRIPE_PERIOD) < STRIPE_WIDTH);

        ctl_cur.mode = in_mode;
        ctl_cur.idx  = in_idx;
        ctl_cur.rgb  = in_rgb;
        ctl_cur.n    = n_cur;
        if (opacity_base_reg == 8'd0)
        begin
            ctl_cur.kind = KIND_CLEAR;
        end
        else if (in_base_nan)
        begin
            ctl_cur.kind = stripe_hit ? KIND_STRIPE : KIND_CLEAR;
        end
        else if (n_cur == '0)
        begin
            ctl_cur.kind = KIND_BLACK;
        end
        else if (n_cur == SIZE_W'(1) || range_cur <= 0 || v_ext <= lo_ext)
        begin
            ctl_cur.kind = KIND_FIRST;
        end
        else if (v_ext >= hi_ext)
        begin
            ctl_cur.kind = KIND_LAST;
        end
        else
        begin
            ctl_cur.kind = KIND_INTERP;
        end
        ctl_cur.safe_on  = (opacity_safe_reg != 8'd0) && !in_safe_nan
                           && ($signed(in_safe) > OVERLAY_THRESH);
        ctl_cur.avoid_on = (opacity_avoid_reg != 8'd0) && !in_avoid_nan
                           && ($signed(in_avoid) > OVERLAY_THRESH);
    end

    // stage a: accepted item, stage b: scaled offset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_a_reg   <= ctl_cur;
            diff_a_reg  <= diff_full[31:0];
            range_a_reg <= range_cur[31:0];
            ctl_b_reg   <= ctl_a_reg;
            prod_b_reg  <= PW'({{SIZE_W{1'b0}}, diff_a_reg}
                               * {32'd0, ctl_a_reg.n - SIZE_W'(1)});
            range_b_reg <= range_a_reg;
        end
    end

    assign num_b = (ctl_b_reg.kind == KIND_INTERP) ? {prod_b_reg, 16'd0} : '0;
    assign dvs_b = (ctl_b_reg.kind == KIND_INTERP) ? range_b_reg : 32'd1;

    lcpr_divider #(
        .LANES (1),
        .NW    (NW),
        .DW    (32),
        .QW    (QW),
        .SW    ($bits(item_ctl_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vb_reg),
        .dividend  (num_b),
        .divisor   (dvs_b),
        .in_side   (ctl_b_reg),
        .out_valid (vq),
        .quotient  (p_q),
        .out_side  (ctl_q)
    );

    // interval index and fraction
    always_comb
    begin
        nm1   = ctl_q.n - SIZE_W'(1);
        nm2   = ctl_q.n - SIZE_W'(2);
        i_raw = p_q[QW-1:FRAC_BITS];
        case (ctl_q.kind)
            KIND_INTERP:
            begin
                if (int'(i_raw) > int'(nm2))
                begin
                    rd_a  = AW'(nm2);
                    s_cur = 16'hFFFF;
                end
                else
                begin
                    rd_a  = i_raw;
                    s_cur = p_q[FRAC_BITS-1:0];
                end
            end
            KIND_LAST:
            begin
                rd_a  = AW'(nm1);
                s_cur = 16'd0;
            end
            default:
            begin
                rd_a  = '0;
                s_cur = 16'd0;
            end
        endcase
        rd_b  = AW'(rd_a + 1'b1);
        wr_en = vq && !ctl_q.mode && (int'(ctl_q.idx) < MAX_COLORS);
    end

    // colormap, loaded and read in item order
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                cmap_mem[AW'(ctl_q.idx)] <= ctl_q.rgb;
            end
            c1_reg <= cmap_mem[rd_a];
            c2_reg <= cmap_mem[rd_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_c_reg  <= ctl_q.kind;
            s_c_reg     <= s_cur;
            safe_c_reg  <= ctl_q.safe_on;
            avoid_c_reg <= ctl_q.avoid_on;
        end
    end

    // linear blend of the two entries, rounded half up, or a fixed color for the clear, stripe and black kinds
    always_comb
    begin
        w_lo = 17'h10000 - {1'b0, s_c_reg};
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = 25'(w_lo * 17'(c1_reg[23-8*c -: 8]))
                     + 25'({1'b0, s_c_reg} * 17'(c2_reg[23-8*c -: 8]))
                     + 25'h8000;
            mix[c] = acc[c][23:16];
        end
        px_base.alpha = opacity_base_reg;
        case (kind_c_reg)
            KIND_CLEAR:
            begin
                px_base = '{alpha: 8'd0, blue: ALPHA_MAX, green: ALPHA_MAX,
                            red: ALPHA_MAX};
            end
            KIND_STRIPE:
            begin
                px_base.red   = STRIPE_RED;
                px_base.green = STRIPE_GB;
                px_base.blue  = STRIPE_GB;
            end
            KIND_BLACK:
            begin
                px_base.red   = 8'd0;
                px_base.green = 8'd0;
                px_base.blue  = 8'd0;
            end
            default:
            begin
                px_base.red   = mix[0];
                px_base.green = mix[1];
                px_base.blue  = mix[2];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_d_reg    <= px_base;
            safe_d_reg  <= safe_c_reg;
            avoid_d_reg <= avoid_c_reg;
        end
    end

    // valid bits; loads stop after the table stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= s_axis_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vq && ctl_q.mode;
            vd_reg <= vc_reg;
        end
    end

    // green safe zone overlay
    lcpr_over u_over_safe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vd_reg),
        .in_px     (px_d_reg),
        .in_on     (safe_d_reg),
        .in_flag   (avoid_d_reg),
        .front_rgb (SAFE_RGB),
        .opacity   (opacity_safe_reg),
        .out_valid (v_o1),
        .out_px    (px_o1),
        .out_flag  (avoid_o1)
    );

    // yellow avoidance overlay
    lcpr_over u_over_avoid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_o1),
        .in_px     (px_o1),
        .in_on     (avoid_o1),
        .in_flag   (1'b0),
        .front_rgb (AVOID_RGB),
        .opacity   (opacity_avoid_reg),
        .out_valid (v_o2),
        .out_px    (px_o2),
        .out_flag  ()
    );

    assign m_axis_tvalid = v_o2;
    assign m_axis_tdata  = px_o2;

endmodule
